[hw/rtl/idafs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package idafs_pkg;

   localparam int ID_WIDTH = 10;
   localparam int FREE_DEPTH_DEFAULT = 1024;
   localparam logic [ID_WIDTH-1:0] ID_LIMIT_RESET = ID_WIDTH'(1023);

   typedef enum logic [0:0] {
      REQ_ALLOCATE = 1'b0,
      REQ_RELEASE  = 1'b1
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_EXHAUSTED  = 2'd1,
      ST_ZERO_ID    = 2'd2,
      ST_STACK_FULL = 2'd3
   } status_type;

   typedef struct packed {
      req_code_type        req_type;
      logic [ID_WIDTH-1:0] released_id;
   } idafs_req_type;

   typedef struct packed {
      logic [ID_WIDTH-1:0] given_id;
      status_type          status;
   } idafs_rsp_type;

endpackage

`default_nettype wire

[hw/rtl/idafs_stack_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module idafs_stack_ram #(
   parameter int DEPTH  = 1024,
   parameter int WIDTH  = 10,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[hw/rtl/id_allocator_free_stack_unit.sv]
// A release, a fresh allocate or a failed allocate is answered in the cycle after
// acceptance; a stack pop goes through the memory read register and the read state first.
// Throughput: one transaction per cycle, except a stack pop, which holds the input in the
// read state while the memory read completes. A result that waits on the receiver holds
// the input until it is taken. Reset is synchronous: the free count and the highest issued
// identifier clear, the limit returns to 1023, and the stack contents are left as is.
`timescale 1ns / 1ps
`default_nettype none

module id_allocator_free_stack_unit
   import idafs_pkg::*;
#(
   parameter int FREE_DEPTH = FREE_DEPTH_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire idafs_req_type       req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output idafs_rsp_type            rsp_data,
   input  wire logic                csr_we,
   input  wire logic [ID_WIDTH-1:0] csr_wdata
);

   localparam int ADDR_W = $clog2(FREE_DEPTH);
   localparam int CNT_W  = $clog2(FREE_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FREE_DEPTH);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_READ = 2'b10
   } state_type;

   state_type           state_ff, state_in;
   logic [ID_WIDTH-1:0] id_limit_ff, id_limit_in;
   logic [ID_WIDTH-1:0] highest_ff, highest_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   idafs_rsp_type       rsp_data_ff, rsp_data_in;

   logic                accept;
   logic                load_rsp;
   logic                wr_en;
   logic                rd_en;
   logic [CNT_W-1:0]    count_dec;
   logic [ID_WIDTH-1:0] rd_data;

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign count_dec = count_ff - CNT_W'(1);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in    = state_ff;
      id_limit_in = csr_we ? csr_wdata : id_limit_ff;
      highest_in  = highest_ff;
      count_in    = count_ff;
      rsp_data_in = rsp_data_ff;
      load_rsp    = 1'b0;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_data_in.given_id = '0;
               rsp_data_in.status   = ST_OK;
               if (req_data.req_type == REQ_ALLOCATE) begin
                  if (count_ff != '0) begin
                     rd_en    = 1'b1;
                     count_in = count_dec;
                     state_in = S_READ;
                  end else if (highest_ff >= id_limit_ff) begin
                     rsp_data_in.status = ST_EXHAUSTED;
                     load_rsp           = 1'b1;
                  end else begin
                     highest_in           = highest_ff + ID_WIDTH'(1);
                     rsp_data_in.given_id = highest_in;
                     load_rsp             = 1'b1;
                  end
               end else begin
                  load_rsp = 1'b1;
                  if (req_data.released_id == '0) begin
                     rsp_data_in.status = ST_ZERO_ID;
                  end else if (count_ff == CNT_FULL) begin
                     rsp_data_in.status = ST_STACK_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
               end
            end
         end
         S_READ: begin
            rsp_data_in.given_id = rd_data;
            rsp_data_in.status   = ST_OK;
            load_rsp             = 1'b1;
            state_in             = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         id_limit_ff  <= ID_LIMIT_RESET;
         highest_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         id_limit_ff  <= id_limit_in;
         highest_ff   <= highest_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   idafs_stack_ram #(
      .DEPTH  (FREE_DEPTH),
      .WIDTH  (ID_WIDTH),
      .ADDR_W (ADDR_W)
   ) u_stack (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (count_ff[ADDR_W-1:0]),
      .wr_data    (req_data.released_id),
      .rd_en      (rd_en),
      .rd_addr    (count_dec[ADDR_W-1:0]),
      .rd_data_ff (rd_data)
   );

   a_read_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> !rsp_valid_ff)
      else $error("Output register occupied during a stack read.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("Free count beyond stack depth.");

   a_highest_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (highest_ff == $past(highest_ff)
                || highest_ff == $past(highest_ff) + ID_WIDTH'(1)))
      else $error("Highest issued identifier jumped.");

   a_failed_zero_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.status == ST_OK || rsp_data_ff.given_id == '0))
      else $error("Nonzero identifier on a failed transaction.");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (count_ff != '0 && state_ff == S_IDLE))
      else $error("Stack read without a stored entry.");

endmodule

`default_nettype wire
